// ===== rtl/sbos_pkg.sv =====
// Shared types and constants for the sparse brick occupancy store.
// No dependencies; used by the top level, sbos_addr and the testbench.
`default_nettype none
package sbos_pkg;

  localparam int GRID_EDGE_MAX       = 64;
  localparam int BRICK_EDGE_MAX      = 8;
  localparam int BRICKS_PER_AXIS_MAX = 16;

  localparam int COORD_W  = $clog2(GRID_EDGE_MAX);
  localparam int ROW_W    = 2 * COORD_W;
  localparam int BAXIS_W  = $clog2(BRICKS_PER_AXIS_MAX);
  localparam int BRICK_W  = 3 * BAXIS_W;
  localparam int FILL_W   = 10;
  localparam int TOTAL_W  = 19;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic [FILL_W-1:0] FILL_MAX = '1;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRICK_EDGE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BRICKS_ACROSS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BRICKS_DOWN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BRICKS_DEEP   = 3'd6;

  typedef struct packed {
    logic [6:0] grid_width;
    logic [6:0] grid_height;
    logic [6:0] grid_depth;
    logic [3:0] brick_edge;
    logic [4:0] bricks_across;
    logic [4:0] bricks_down;
    logic [4:0] bricks_deep;
  } cfg_t;

  typedef struct packed {
    logic               in_range;
    logic               hit;
    logic [ROW_W-1:0]   cell_row;
    logic [COORD_W-1:0] cell_bit;
    logic [BRICK_W-1:0] brick_idx;
  } addr_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RMW  = 4'b0010,
    ST_CLR  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/sparse_brick_occupancy_store.sv =====
// Top level of the sparse brick occupancy store: control, config, memories.
// Depends on sbos_pkg, sbos_addr and sbos_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries op, coordinates and solid_value.
//   Result channel (out_valid/out_ready) returns one result per item.
//   Config port: cfg_we writes cfg_data into register cfg_addr at once.
//   Write and query items: the transfer cycle issues the reads of the cell row
//   memory and brick memory; the RMW step then modifies, writes back and
//   loads the output register. The next item is taken the cycle after.
//   Only one item is in work at a time: in_ready is high only while idle.
//   A clear item sweeps both memories, one row a cycle, over all 4096 rows,
//   then its result is loaded. After reset the same sweep runs before
//   in_ready rises; config writes are taken during it.
//   While out_valid is held by a stalled receiver the result stays put, and a
//   finished item waits in its write-back step until the output register frees.
`default_nettype none
module sparse_brick_occupancy_store (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_valid,
  output logic                                          in_ready,
  input  wire logic [1:0]                               in_op,
  input  wire logic [7:0]                               in_cell_x,
  input  wire logic [7:0]                               in_cell_y,
  input  wire logic [7:0]                               in_cell_z,
  input  wire logic                                     in_solid_value,
  output logic                                          out_valid,
  input  wire logic                                     out_ready,
  output logic                                          out_cell_is_solid,
  output logic                                          out_brick_occupied,
  output logic                                          out_in_range,
  output logic [sbos_pkg::TOTAL_W-1:0]                  out_solid_total,
  input  wire logic                                     cfg_we,
  input  wire logic [sbos_pkg::CFG_IDX_W-1:0]           cfg_addr,
  input  wire logic [sbos_pkg::CFG_W-1:0]               cfg_data
);

  localparam int ROW_W   = sbos_pkg::ROW_W;
  localparam int BRICK_W = sbos_pkg::BRICK_W;
  localparam int FILL_W  = sbos_pkg::FILL_W;
  localparam int TOTAL_W = sbos_pkg::TOTAL_W;
  localparam int ROW_BITS = sbos_pkg::GRID_EDGE_MAX;

  sbos_pkg::state_t state_r, state_nxt;
  sbos_pkg::cfg_t   cfg_r;
  sbos_pkg::addr_t  addr_now, addr_r;
  logic [1:0]       op_r;
  logic             solid_r;
  logic             report_r, report_nxt;
  logic [BRICK_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_solid_r, out_solid_nxt;
  logic               out_occ_r, out_occ_nxt;
  logic               out_range_r, out_range_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;

  logic                cell_we, brick_we;
  logic [ROW_W-1:0]    cell_waddr, cell_raddr;
  logic [ROW_BITS-1:0] cell_wdata, cell_rdata;
  logic [BRICK_W-1:0]  brick_waddr, brick_raddr;
  logic [FILL_W:0]     brick_wdata, brick_rdata;

  logic                accept, out_free;
  logic                old_bit, new_bit, new_flag;
  logic [FILL_W-1:0]   old_cnt, new_cnt;
  logic [ROW_BITS-1:0] new_row;
  logic                do_write;

  sbos_addr u_addr (
    .cell_x (in_cell_x),
    .cell_y (in_cell_y),
    .cell_z (in_cell_z),
    .cfg    (cfg_r),
    .addr   (addr_now)
  );

  sbos_ram #(.ADDR_W(ROW_W), .DATA_W(ROW_BITS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  sbos_ram #(.ADDR_W(BRICK_W), .DATA_W(FILL_W + 1)) u_brick_ram (
    .clk   (clk),
    .we    (brick_we),
    .waddr (brick_waddr),
    .wdata (brick_wdata),
    .raddr (brick_raddr),
    .rdata (brick_rdata)
  );

  assign in_ready  = (state_r == sbos_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_cell_is_solid  = out_solid_r;
  assign out_brick_occupied = out_occ_r;
  assign out_in_range       = out_range_r;
  assign out_solid_total    = out_total_r;

  assign cell_raddr  = (state_r == sbos_pkg::ST_IDLE) ? addr_now.cell_row : addr_r.cell_row;
  assign brick_raddr = (state_r == sbos_pkg::ST_IDLE) ? addr_now.brick_idx : addr_r.brick_idx;

  always_comb begin
    old_bit  = cell_rdata[addr_r.cell_bit];
    old_cnt  = brick_rdata[FILL_W-1:0];
    new_bit  = old_bit;
    new_cnt  = old_cnt;
    new_flag = brick_rdata[FILL_W];
    total_nxt = total_r;
    do_write = (op_r == sbos_pkg::OP_WRITE) && addr_r.hit;
    if (do_write) begin
      if (solid_r) begin
        new_bit = 1'b1;
        if (!old_bit) begin
          total_nxt = total_r + TOTAL_W'(1);
          if (old_cnt < sbos_pkg::FILL_MAX) begin
            new_cnt = old_cnt + FILL_W'(1);
          end
        end
        new_flag = 1'b1;
      end else begin
        new_bit = 1'b0;
        if (old_bit) begin
          if (total_r != '0) begin
            total_nxt = total_r - TOTAL_W'(1);
          end
          if (old_cnt != '0) begin
            new_cnt = old_cnt - FILL_W'(1);
          end
        end
        new_flag = (new_cnt != '0);
      end
    end
    new_row = cell_rdata;
    new_row[addr_r.cell_bit] = new_bit;
  end

  always_comb begin
    state_nxt     = state_r;
    report_nxt    = report_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_solid_nxt = out_solid_r;
    out_occ_nxt   = out_occ_r;
    out_range_nxt = out_range_r;
    out_total_nxt = out_total_r;
    cell_we     = 1'b0;
    brick_we    = 1'b0;
    cell_waddr  = addr_r.cell_row;
    cell_wdata  = new_row;
    brick_waddr = addr_r.brick_idx;
    brick_wdata = {new_flag, new_cnt};
    case (state_r)
      sbos_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op == sbos_pkg::OP_CLEAR) begin
            state_nxt   = sbos_pkg::ST_CLR;
            report_nxt  = 1'b1;
            clr_cnt_nxt = '0;
          end else begin
            state_nxt = sbos_pkg::ST_RMW;
          end
        end
      end
      sbos_pkg::ST_RMW: begin
        if (out_free) begin
          cell_we       = do_write;
          brick_we      = do_write;
          out_valid_nxt = 1'b1;
          out_solid_nxt = addr_r.hit && new_bit;
          out_occ_nxt   = addr_r.hit && new_flag;
          out_range_nxt = addr_r.in_range;
          out_total_nxt = total_nxt;
          state_nxt     = sbos_pkg::ST_IDLE;
        end
      end
      sbos_pkg::ST_CLR: begin
        cell_we     = 1'b1;
        brick_we    = 1'b1;
        cell_waddr  = clr_cnt_r;
        cell_wdata  = '0;
        brick_waddr = clr_cnt_r;
        brick_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + BRICK_W'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = report_r ? sbos_pkg::ST_FIN : sbos_pkg::ST_IDLE;
        end
      end
      sbos_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_solid_nxt = 1'b0;
          out_occ_nxt   = 1'b0;
          out_range_nxt = 1'b0;
          out_total_nxt = '0;
          report_nxt    = 1'b0;
          state_nxt     = sbos_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sbos_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbos_pkg::ST_CLR;
      report_r    <= 1'b0;
      clr_cnt_r   <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      cfg_r.grid_width    <= 7'd64;
      cfg_r.grid_height   <= 7'd64;
      cfg_r.grid_depth    <= 7'd64;
      cfg_r.brick_edge    <= 4'd8;
      cfg_r.bricks_across <= 5'd8;
      cfg_r.bricks_down   <= 5'd8;
      cfg_r.bricks_deep   <= 5'd8;
    end else begin
      state_r     <= state_nxt;
      report_r    <= report_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept && in_op == sbos_pkg::OP_CLEAR) begin
        total_r <= '0;
      end else if (state_r == sbos_pkg::ST_RMW && out_free) begin
        total_r <= total_nxt;
      end
      if (cfg_we) begin
        case (cfg_addr)
          sbos_pkg::REG_GRID_WIDTH:    cfg_r.grid_width    <= cfg_data;
          sbos_pkg::REG_GRID_HEIGHT:   cfg_r.grid_height   <= cfg_data;
          sbos_pkg::REG_GRID_DEPTH:    cfg_r.grid_depth    <= cfg_data;
          sbos_pkg::REG_BRICK_EDGE:    cfg_r.brick_edge    <= cfg_data[3:0];
          sbos_pkg::REG_BRICKS_ACROSS: cfg_r.bricks_across <= cfg_data[4:0];
          sbos_pkg::REG_BRICKS_DOWN:   cfg_r.bricks_down   <= cfg_data[4:0];
          sbos_pkg::REG_BRICKS_DEEP:   cfg_r.bricks_deep   <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_solid_r <= out_solid_nxt;
    out_occ_r   <= out_occ_nxt;
    out_range_r <= out_range_nxt;
    out_total_r <= out_total_nxt;
    if (accept) begin
      op_r    <= in_op;
      solid_r <= in_solid_value;
      addr_r.cell_row  <= addr_now.cell_row;
      addr_r.cell_bit  <= addr_now.cell_bit;
      addr_r.brick_idx <= addr_now.brick_idx;
      addr_r.in_range  <= addr_now.in_range &&
                          (in_op == sbos_pkg::OP_WRITE || in_op == sbos_pkg::OP_QUERY);
      addr_r.hit       <= addr_now.hit &&
                          (in_op == sbos_pkg::OP_WRITE || in_op == sbos_pkg::OP_QUERY);
    end
  end

  a_clr_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbos_pkg::ST_CLR) |-> !in_ready)
    else $error("input taken during clearing sweep");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == sbos_pkg::ST_RMW || state_r == sbos_pkg::ST_CLR))
    else $error("transfer did not start work");

  a_clear_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sbos_pkg::ST_FIN && out_free) |=> (out_valid && out_solid_total == '0))
    else $error("clear result not zero");

  a_write_only_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    cell_we |-> (state_r == sbos_pkg::ST_RMW || state_r == sbos_pkg::ST_CLR))
    else $error("cell memory written outside a work step");

endmodule
`default_nettype wire

// ===== rtl/sbos_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none
module sbos_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/sbos_addr.sv =====
// Range check and cell/brick address generation for one item.
// Depends on sbos_pkg.
`default_nettype none
module sbos_addr (
  input  wire logic [7:0]    cell_x,
  input  wire logic [7:0]    cell_y,
  input  wire logic [7:0]    cell_z,
  input  wire sbos_pkg::cfg_t cfg,
  output sbos_pkg::addr_t    addr
);

  localparam int CW = sbos_pkg::COORD_W;
  localparam int BW = sbos_pkg::BAXIS_W;

  // reciprocal multiply, exact for coordinates below 64
  function automatic logic [CW-1:0] div_edge(input logic [CW-1:0] v, input logic [3:0] e);
    logic [19:0]   p;
    logic [CW-1:0] q;
    p = '0;
    case (e)
      4'd1: q = v;
      4'd2: q = v >> 1;
      4'd3: begin
        p = 20'(v) * 20'd1366;
        q = p[12 +: CW];
      end
      4'd4: q = v >> 2;
      4'd5: begin
        p = 20'(v) * 20'd820;
        q = p[12 +: CW];
      end
      4'd6: begin
        p = 20'(v) * 20'd683;
        q = p[12 +: CW];
      end
      4'd7: begin
        p = 20'(v) * 20'd586;
        q = p[12 +: CW];
      end
      4'd8: q = v >> 3;
      default: q = v;
    endcase
    return q;
  endfunction

  function automatic logic [6:0] clamp7(input logic [6:0] v);
    return (v > 7'(sbos_pkg::GRID_EDGE_MAX)) ? 7'(sbos_pkg::GRID_EDGE_MAX) : v;
  endfunction

  function automatic logic [4:0] clamp5(input logic [4:0] v);
    return (v > 5'(sbos_pkg::BRICKS_PER_AXIS_MAX)) ? 5'(sbos_pkg::BRICKS_PER_AXIS_MAX) : v;
  endfunction

  logic [6:0]    gw, gh, gd;
  logic [3:0]    edge_len;
  logic [4:0]    bw, bh, bd;
  logic [CW-1:0] ux, uy, uz, bx, by, bz;
  logic [8:0]    zy;
  logic [13:0]   lin;

  always_comb begin
    gw = clamp7(cfg.grid_width);
    gh = clamp7(cfg.grid_height);
    gd = clamp7(cfg.grid_depth);
    bw = clamp5(cfg.bricks_across);
    bh = clamp5(cfg.bricks_down);
    bd = clamp5(cfg.bricks_deep);
    if (cfg.brick_edge == 4'd0) begin
      edge_len = 4'd1;
    end else if (cfg.brick_edge > 4'(sbos_pkg::BRICK_EDGE_MAX)) begin
      edge_len = 4'(sbos_pkg::BRICK_EDGE_MAX);
    end else begin
      edge_len = cfg.brick_edge;
    end
    ux = cell_x[CW-1:0];
    uy = cell_y[CW-1:0];
    uz = cell_z[CW-1:0];
    bx = div_edge(ux, edge_len);
    by = div_edge(uy, edge_len);
    bz = div_edge(uz, edge_len);
    addr.in_range = !cell_x[7] && !cell_y[7] && !cell_z[7] &&
                    (cell_x[6:0] < gw) && (cell_y[6:0] < gh) && (cell_z[6:0] < gd);
    addr.hit = addr.in_range && ({1'b0, bx} < 7'(bw)) && ({1'b0, by} < 7'(bh)) &&
               ({1'b0, bz} < 7'(bd));
    zy = 9'(bz[BW-1:0] * bh) + 9'(by[BW-1:0]);
    lin = 14'(zy * bw) + 14'(bx[BW-1:0]);
    addr.brick_idx = lin[sbos_pkg::BRICK_W-1:0];
    addr.cell_row = {uz, uy};
    addr.cell_bit = ux;
  end

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for sparse_brick_occupancy_store: random and directed
// write/query/clear traffic checked against an in-bench occupancy predictor.
// Depends on sbos_pkg and the RTL top level.
`timescale 1ns / 1ps

class occupancy_scoreboard;
  typedef struct {
    bit        solid;
    bit        occupied;
    bit        in_rng;
    bit [18:0] total;
  } occ_result_t;

  bit [6:0]  gw, gh, gd;
  bit [3:0]  edge_raw;
  bit [4:0]  bw, bh, bd;
  bit        cells[int];
  int        fill[int];
  bit        flags[int];
  bit [18:0] total;
  occ_result_t pending[$];
  int        errors;

  function void reset_state();
    gw = 64; gh = 64; gd = 64; edge_raw = 8; bw = 8; bh = 8; bd = 8;
    cells.delete(); fill.delete(); flags.delete(); total = 0;
  endfunction

  function void set_reg(bit [2:0] idx, bit [6:0] val);
    case (idx)
      sbos_pkg::REG_GRID_WIDTH:    gw = val;
      sbos_pkg::REG_GRID_HEIGHT:   gh = val;
      sbos_pkg::REG_GRID_DEPTH:    gd = val;
      sbos_pkg::REG_BRICK_EDGE:    edge_raw = val[3:0];
      sbos_pkg::REG_BRICKS_ACROSS: bw = val[4:0];
      sbos_pkg::REG_BRICKS_DOWN:   bh = val[4:0];
      sbos_pkg::REG_BRICKS_DEEP:   bd = val[4:0];
      default: ;
    endcase
  endfunction

  function int cap(int v, int hi);
    return v > hi ? hi : v;
  endfunction

  function void note_transfer(bit [1:0] op, bit [7:0] xr, bit [7:0] yr, bit [7:0] zr,
                              bit sv);
    occ_result_t r;
    int x, y, z, ew, bi, ci;
    r = '{0, 0, 0, 0};
    x = $signed(xr); y = $signed(yr); z = $signed(zr);
    ew = edge_raw == 0 ? 1 : cap(edge_raw, sbos_pkg::BRICK_EDGE_MAX);
    if (op == sbos_pkg::OP_CLEAR) begin
      cells.delete(); fill.delete(); flags.delete(); total = 0;
    end else if (op == sbos_pkg::OP_WRITE || op == sbos_pkg::OP_QUERY) begin
      if (x >= 0 && y >= 0 && z >= 0 && x < cap(gw, 64) && y < cap(gh, 64) &&
          z < cap(gd, 64)) begin
        r.in_rng = 1;
        if (x / ew < cap(bw, 16) && y / ew < cap(bh, 16) && z / ew < cap(bd, 16)) begin
          bi = ((z / ew) * cap(bh, 16) + y / ew) * cap(bw, 16) + x / ew;
          ci = (z * 64 + y) * 64 + x;
          if (!cells.exists(ci)) cells[ci] = 0;
          if (!fill.exists(bi)) fill[bi] = 0;
          if (!flags.exists(bi)) flags[bi] = 0;
          if (op == sbos_pkg::OP_WRITE) begin
            if (sv) begin
              if (!cells[ci]) begin
                cells[ci] = 1; total++;
                if (fill[bi] < 1023) fill[bi]++;
              end
              flags[bi] = 1;
            end else begin
              if (cells[ci]) begin
                cells[ci] = 0;
                if (total > 0) total--;
                if (fill[bi] > 0) fill[bi]--;
              end
              flags[bi] = fill[bi] != 0;
            end
          end
          r.solid = cells[ci];
          r.occupied = flags[bi];
        end
      end
    end
    r.total = total;
    pending.push_back(r);
  endfunction

  function void check_result(bit s, bit o, bit i, bit [18:0] t);
    occ_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result solid=%0b occ=%0b rng=%0b total=%0d",
               $time, s, o, i, t);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e.solid != s) begin
      $display("%0t: cell_is_solid expected %0b actual %0b", $time, e.solid, s); errors++;
    end
    if (e.occupied != o) begin
      $display("%0t: brick_occupied expected %0b actual %0b", $time, e.occupied, o);
      errors++;
    end
    if (e.in_rng != i) begin
      $display("%0t: in_range expected %0b actual %0b", $time, e.in_rng, i); errors++;
    end
    if (e.total != t) begin
      $display("%0t: solid_total expected %0d actual %0d", $time, e.total, t); errors++;
    end
  endfunction
endclass

module testbench;

  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk, rst_n;
  logic in_valid, in_ready, in_solid_value;
  logic [1:0] in_op;
  logic [7:0] in_cell_x, in_cell_y, in_cell_z;
  logic out_valid, out_ready, out_cell_is_solid, out_brick_occupied, out_in_range;
  logic [sbos_pkg::TOTAL_W-1:0] out_solid_total;
  logic cfg_we;
  logic [sbos_pkg::CFG_IDX_W-1:0] cfg_addr;
  logic [sbos_pkg::CFG_W-1:0] cfg_data;

  occupancy_scoreboard board;
  int send_idle_pct, stall_pct;
  int quiet_cycles;

  sparse_brick_occupancy_store dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready)
        board.check_result(out_cell_is_solid, out_brick_occupied, out_in_range,
                           out_solid_total);
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_reg(logic [sbos_pkg::CFG_IDX_W-1:0] idx,
                           logic [sbos_pkg::CFG_W-1:0] val);
    cfg_we <= 1; cfg_addr <= idx; cfg_data <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic send_item(logic [1:0] op, logic [7:0] x, logic [7:0] y, logic [7:0] z,
                           logic sv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; in_op <= op; in_cell_x <= x; in_cell_y <= y; in_cell_z <= z;
    in_solid_value <= sv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_transfer(op, x, y, z, sv);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_geometry(int g_w, int g_h, int g_d, int e, int b_w, int b_h, int b_d);
    write_reg(sbos_pkg::REG_GRID_WIDTH, 7'(g_w));
    write_reg(sbos_pkg::REG_GRID_HEIGHT, 7'(g_h));
    write_reg(sbos_pkg::REG_GRID_DEPTH, 7'(g_d));
    write_reg(sbos_pkg::REG_BRICK_EDGE, 7'(e));
    write_reg(sbos_pkg::REG_BRICKS_ACROSS, 7'(b_w));
    write_reg(sbos_pkg::REG_BRICKS_DOWN, 7'(b_h));
    write_reg(sbos_pkg::REG_BRICKS_DEEP, 7'(b_d));
    cfg_we <= 0;
  endtask

  function automatic logic [7:0] pick_coord(int lim);
    int r;
    r = $urandom_range(99);
    if (r < 85) return 8'($urandom_range(lim > 0 ? lim - 1 : 0));
    if (r < 92) return 8'(lim + $urandom_range(3));
    return 8'($urandom);
  endfunction

  task automatic random_phase(int count, int lim, bit with_clears);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (with_clears && r < 2)
        send_item(sbos_pkg::OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom));
      else if (r < 4)
        send_item(OP_SPARE, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      else
        send_item(r < 55 ? sbos_pkg::OP_WRITE : sbos_pkg::OP_QUERY, pick_coord(lim),
                  pick_coord(lim), pick_coord(lim), $urandom_range(99) < 65);
    end
  endtask

  initial begin
    board = new();
    board.reset_state();
    rst_n = 0; in_valid = 0; in_op = 0; in_cell_x = 0; in_cell_y = 0; in_cell_z = 0;
    in_solid_value = 0; out_ready = 0; cfg_we = 0; cfg_addr = 0; cfg_data = 0;
    send_idle_pct = 0; stall_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    send_item(sbos_pkg::OP_WRITE, 0, 0, 0, 1);
    send_item(sbos_pkg::OP_WRITE, 63, 63, 63, 1);
    send_item(sbos_pkg::OP_QUERY, 63, 63, 63, 0);
    send_item(sbos_pkg::OP_WRITE, 0, 0, 0, 1);
    send_item(sbos_pkg::OP_WRITE, 1, 0, 0, 0);
    send_item(sbos_pkg::OP_WRITE, 0, 0, 0, 0);
    send_item(sbos_pkg::OP_QUERY, 0, 0, 0, 1);
    send_item(sbos_pkg::OP_WRITE, 8'h80, 8'h7f, 8'hff, 1);
    send_item(sbos_pkg::OP_QUERY, 64, 0, 0, 0);
    send_item(sbos_pkg::OP_QUERY, 0, 8'hff, 0, 0);
    send_item(sbos_pkg::OP_WRITE, 7, 7, 7, 1);
    send_item(sbos_pkg::OP_WRITE, 8, 0, 0, 1);
    send_item(OP_SPARE, 8'h55, 8'haa, 8'h7f, 1);
    send_item(sbos_pkg::OP_CLEAR, 0, 0, 0, 0);
    send_item(sbos_pkg::OP_QUERY, 7, 7, 7, 0);
    drain();

    set_geometry(64, 64, 64, 8, 4, 4, 4);
    send_item(sbos_pkg::OP_WRITE, 40, 3, 3, 1);
    send_item(sbos_pkg::OP_WRITE, 20, 20, 20, 1);
    send_item(sbos_pkg::OP_QUERY, 20, 20, 20, 0);
    drain();

    set_geometry(1, 1, 1, 0, 1, 1, 1);
    send_item(sbos_pkg::OP_WRITE, 0, 0, 0, 1);
    send_item(sbos_pkg::OP_QUERY, 1, 0, 0, 1);
    drain();
    set_geometry(127, 127, 127, 15, 31, 31, 31);
    send_item(sbos_pkg::OP_QUERY, 63, 0, 0, 1);
    send_item(sbos_pkg::OP_WRITE, 63, 0, 0, 0);
    send_item(sbos_pkg::OP_CLEAR, 0, 0, 0, 0);
    drain();

    set_geometry(8, 8, 8, 2, 4, 4, 4);
    random_phase(250, 8, 1);
    send_idle_pct = 50;
    random_phase(200, 8, 1);
    send_idle_pct = 0; stall_pct = 50;
    random_phase(200, 8, 0);
    send_idle_pct = 8; stall_pct = 8;
    drain();
    send_item(sbos_pkg::OP_CLEAR, 0, 0, 0, 0);
    drain();
    set_geometry(12, 10, 9, 3, 3, 4, 2);
    random_phase(250, 12, 0);
    send_idle_pct = 0; stall_pct = 0;
    drain();
    send_item(sbos_pkg::OP_CLEAR, 0, 0, 0, 0);
    drain();
    set_geometry(64, 64, 64, 8, 8, 8, 8);
    random_phase(150, 64, 0);
    drain();
    send_item(sbos_pkg::OP_CLEAR, 0, 0, 0, 0);
    drain();
    set_geometry(5, 6, 7, 1, 16, 16, 16);
    send_idle_pct = 50; stall_pct = 50;
    random_phase(200, 7, 0);
    drain();

    if (board.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
